>>> rtl/tlbpt_pkg.sv
// shared types and constants of the tlb page table translator
// no dependencies; imported by the controller, the datapath and the top level
package tlbpt_pkg;

    localparam int ADDR_W          = 16;
    localparam int OFFSET_BITS     = 8;
    localparam int PAGE_W          = ADDR_W - OFFSET_BITS;
    localparam int FRAME_W         = ADDR_W - OFFSET_BITS;
    localparam int PAGE_COUNT      = 1 << PAGE_W;
    localparam int CNT_W           = 32;
    localparam int TLB_ENTRIES_DEF = 16;

    typedef enum logic {
        ST_IDLE,
        ST_RESOLVE
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic lookup;
        logic commit;
    } t_cmd;

endpackage

>>> rtl/tlbpt_ctrl.sv
// controller state machine of the tlb page table translator
// depends on tlbpt_pkg for the state and command types
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.lookup = 1'b0;
        o_cmd.commit = 1'b0;
        busy         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                busy         = 1'b1;
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/tlbpt_datapath.sv
// datapath of the tlb page table translator: tlb cam, page table memory,
// frame allocator, counters and result registers; depends on tlbpt_pkg
module tlbpt_datapath
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_logical_address,
    output logic              o_result_valid,
    output logic [ADDR_W-1:0] o_physical_address,
    output logic              o_tlb_hit,
    output logic              o_page_fault,
    output logic [CNT_W-1:0]  o_access_total,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_fault_total
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);

    // tlb entries
    logic [PAGE_W-1:0]  r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0] r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [IDX_W-1:0]   r_fifo_ptr;

    // page table
    logic [FRAME_W-1:0]    r_pt_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_pt_valid_bits;
    logic [FRAME_W-1:0]    r_next_free;

    // lookup stage registers
    logic [PAGE_W-1:0]      r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_hit;
    logic [FRAME_W-1:0]     r_hit_frame;
    logic                   r_pt_valid;
    logic [FRAME_W-1:0]     r_pt_frame;

    // counters and result
    logic [CNT_W-1:0]  r_access_cnt;
    logic [CNT_W-1:0]  r_hit_cnt;
    logic [CNT_W-1:0]  r_fault_cnt;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_phys;
    logic              r_out_hit;
    logic              r_out_fault;

    logic [PAGE_W-1:0]      w_page;
    logic [TLB_ENTRIES-1:0] w_match;
    logic [TLB_ENTRIES-1:0] w_first;
    logic [FRAME_W-1:0]     w_cam_frame;
    logic [FRAME_W-1:0]     w_frame;
    logic                   w_fault;

    assign w_page = i_logical_address[ADDR_W-1:OFFSET_BITS];

    // parallel compare, lowest matching entry wins
    always_comb begin
        w_cam_frame = '0;
        for (int e = 0; e < TLB_ENTRIES; e++) begin
            w_match[e] = r_tlb_valid[e] && (r_tlb_page[e] == w_page);
        end
        w_first = w_match & (~w_match + TLB_ENTRIES'(1));
        for (int e = 0; e < TLB_ENTRIES; e++) begin
            w_cam_frame = w_cam_frame | (w_first[e] ? r_tlb_frame[e] : '0);
        end
    end

    assign w_fault = !r_hit && !r_pt_valid;
    assign w_frame = r_hit ? r_hit_frame : (r_pt_valid ? r_pt_frame : r_next_free);

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_page      <= w_page;
            r_offset    <= i_logical_address[OFFSET_BITS-1:0];
            r_hit       <= |w_match;
            r_hit_frame <= w_cam_frame;
            r_pt_valid  <= r_pt_valid_bits[w_page];
        end
    end

    // page table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_pt_frame <= r_pt_mem[w_page];
        end
        if (i_cmd.commit && w_fault) begin
            r_pt_mem[r_page] <= r_next_free;
        end
    end

    // tlb payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_hit) begin
            r_tlb_page[r_fifo_ptr]  <= r_page;
            r_tlb_frame[r_fifo_ptr] <= w_frame;
        end
    end

    // control state, allocator and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid     <= '0;
            r_fifo_ptr      <= '0;
            r_pt_valid_bits <= '0;
            r_next_free     <= '0;
            r_access_cnt    <= '0;
            r_hit_cnt       <= '0;
            r_fault_cnt     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.commit;
            if (i_cmd.commit) begin
                if (!(&r_access_cnt)) begin
                    r_access_cnt <= r_access_cnt + 1'b1;
                end
                if (r_hit && !(&r_hit_cnt)) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end
                if (w_fault) begin
                    if (!(&r_fault_cnt)) begin
                        r_fault_cnt <= r_fault_cnt + 1'b1;
                    end
                    r_pt_valid_bits[r_page] <= 1'b1;
                    r_next_free             <= r_next_free + 1'b1;
                end
                if (!r_hit) begin
                    r_tlb_valid[r_fifo_ptr] <= 1'b1;
                    r_fifo_ptr <= (r_fifo_ptr == IDX_W'(TLB_ENTRIES - 1)) ?
                                  '0 : r_fifo_ptr + 1'b1;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_phys      <= {w_frame, r_offset};
            r_out_hit   <= r_hit;
            r_out_fault <= w_fault;
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_tlb_hit          = r_out_hit;
    assign o_page_fault       = r_out_fault;
    assign o_access_total     = r_access_cnt;
    assign o_hit_total        = r_hit_cnt;
    assign o_fault_total      = r_fault_cnt;

endmodule

>>> rtl/tlb_page_table_translator.sv
// top level of the tlb page table translator
// depends on tlbpt_pkg, tlbpt_ctrl and tlbpt_datapath
//
// usage
// - command channel: drive i_logical_address and raise start; the beat is
//   taken at a rising edge with start high and busy low
// - the page (upper 8 bits) is searched in a fully associative tlb; on a
//   miss the page table memory is read, and on a page fault the next free
//   frame (counting up from 0, wrapping) is assigned
// - every miss refills one tlb slot in round-robin order
// - result channel: o_result_valid is high for exactly one cycle with the
//   physical address, hit/fault flags and saturating 32-bit totals
// - the result strobe rises at the same edge at which busy drops, the edge
//   that ends the resolve state entered at the accepting edge
// - no new address is taken until the last one has left resolve; the tlb
//   compare and the page table memory read share the accept cycle, the
//   update takes the resolve cycle
// - busy is high for the one update cycle after each accepted beat
// - the receiver cannot stall: each result is taken in its strobe cycle
// - reset (synchronous, active low) invalidates all tlb entries and page
//   table entries at once and clears the fifo pointer, allocator and totals;
//   the block takes addresses in the first cycle after reset
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] i_logical_address,
    output logic              busy,
    output logic              o_result_valid,
    output logic [ADDR_W-1:0] o_physical_address,
    output logic              o_tlb_hit,
    output logic              o_page_fault,
    output logic [CNT_W-1:0]  o_access_total,
    output logic [CNT_W-1:0]  o_hit_total,
    output logic [CNT_W-1:0]  o_fault_total
);

    t_cmd w_cmd;

    // sequencer: idle -> resolve -> idle
    tlbpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // lookup, table update and result registers
    tlbpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_logical_address  (i_logical_address),
        .o_result_valid     (o_result_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_access_total     (o_access_total),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

    // an accepted beat always moves the sequencer into its update cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // every update cycle yields exactly one result strobe
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_result_valid)
        else $error("update cycle without result");

    // a tlb hit never reports a page fault
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_tlb_hit && o_page_fault))
        else $error("hit and fault flagged together");

    // hit and fault totals cannot pass the access total
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_hit_total <= o_access_total) &&
                           (o_fault_total <= o_access_total))
        else $error("totals out of order");

endmodule

>>> sim/tb_tlbpt_scoreboard_pkg.sv
// scoreboard for the tlb page table translator: translation predictor and result check
// depends on tlbpt_pkg for widths and table sizes
package tb_tlbpt_scoreboard_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        logic              hit;
        logic              fault;
        logic [CNT_W-1:0]  access_total;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  fault_total;
    } t_xlat_beat;

    class t_xlat_scoreboard;
        // shadow copy of the translator state
        bit                 tlb_used  [TLB_ENTRIES_DEF];
        bit [PAGE_W-1:0]    tlb_page  [TLB_ENTRIES_DEF];
        bit [FRAME_W-1:0]   tlb_frame [TLB_ENTRIES_DEF];
        bit                 mapped    [PAGE_COUNT];
        bit [FRAME_W-1:0]   page_frame[PAGE_COUNT];
        int unsigned        refill_slot;
        bit [FRAME_W-1:0]   free_frame;
        bit [CNT_W-1:0]     n_access;
        bit [CNT_W-1:0]     n_hit;
        bit [CNT_W-1:0]     n_fault;

        t_xlat_beat         expected_q[$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        seen_hits;
        int unsigned        seen_faults;

        function bit [CNT_W-1:0] sat_inc(bit [CNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function t_xlat_beat translate(logic [ADDR_W-1:0] addr);
            bit [PAGE_W-1:0]      page;
            bit [OFFSET_BITS-1:0] offset;
            bit [FRAME_W-1:0]     frame;
            bit                   hit;
            bit                   fault;
            t_xlat_beat           r;
            page   = addr[ADDR_W-1:OFFSET_BITS];
            offset = addr[OFFSET_BITS-1:0];
            frame  = '0;
            hit    = 1'b0;
            fault  = 1'b0;
            n_access = sat_inc(n_access);
            // lowest matching valid slot wins
            for (int i = 0; i < TLB_ENTRIES_DEF; i++) begin
                if (!hit && tlb_used[i] && tlb_page[i] == page) begin
                    hit   = 1'b1;
                    frame = tlb_frame[i];
                end
            end
            if (hit) begin
                n_hit = sat_inc(n_hit);
            end else begin
                if (mapped[page]) begin
                    frame = page_frame[page];
                end else begin
                    // allocator wraps through all frames, old mappings stay
                    fault            = 1'b1;
                    n_fault          = sat_inc(n_fault);
                    frame            = free_frame;
                    page_frame[page] = frame;
                    mapped[page]     = 1'b1;
                    free_frame       = free_frame + 1'b1;
                end
                tlb_page[refill_slot]  = page;
                tlb_frame[refill_slot] = frame;
                tlb_used[refill_slot]  = 1'b1;
                refill_slot = (refill_slot + 1) % TLB_ENTRIES_DEF;
            end
            r.phys_addr    = {frame, offset};
            r.hit          = hit;
            r.fault        = fault;
            r.access_total = n_access;
            r.hit_total    = n_hit;
            r.fault_total  = n_fault;
            return r;
        endfunction

        function void note_address(logic [ADDR_W-1:0] addr);
            expected_q = {expected_q, translate(addr)};
        endfunction

        function void field_check(string name, logic [CNT_W-1:0] exp_v,
                                  logic [CNT_W-1:0] act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_xlat_beat got);
            t_xlat_beat exp;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no translation pending, actual %0h", $time, got);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            seen_hits   += got.hit;
            seen_faults += got.fault;
            field_check("physical_address", CNT_W'(exp.phys_addr), CNT_W'(got.phys_addr));
            field_check("tlb_hit",          CNT_W'(exp.hit),       CNT_W'(got.hit));
            field_check("page_fault",       CNT_W'(exp.fault),     CNT_W'(got.fault));
            field_check("access_total",     exp.access_total,      got.access_total);
            field_check("hit_total",        exp.hit_total,         got.hit_total);
            field_check("fault_total",      exp.fault_total,       got.fault_total);
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

endpackage

>>> sim/tb_tlb_page_table_translator.sv
// testbench top of the tlb page table translator: directed and random address beats
// depends on tlbpt_pkg, tb_tlbpt_scoreboard_pkg and the tlb_page_table_translator rtl
module tb_tlb_page_table_translator;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;
    import tb_tlbpt_scoreboard_pkg::*;

    // result delay used to size the closing idle wait
    localparam int RESULT_LATENCY  = 2;
    // cycles with neither an accepted beat nor a result before giving up
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int RECENT_DEPTH    = 10;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic [ADDR_W-1:0] i_logical_address;
    logic              busy;
    logic              o_result_valid;
    logic [ADDR_W-1:0] o_physical_address;
    logic              o_tlb_hit;
    logic              o_page_fault;
    logic [CNT_W-1:0]  o_access_total;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_fault_total;

    t_xlat_scoreboard  sb = new();
    int unsigned       stall_cycles = 0;
    int unsigned       pages_touched = 0;

    // page history used to steer random beats toward hits and table reads
    logic [PAGE_W-1:0] recent_pages[$];
    logic [PAGE_W-1:0] known_pages[$];
    bit                page_seen[PAGE_COUNT];

    tlb_page_table_translator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_logical_address  (i_logical_address),
        .busy               (busy),
        .o_result_valid     (o_result_valid),
        .o_physical_address (o_physical_address),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_access_total     (o_access_total),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // monitor: reads pre-edge values, tb drives with nonblocking assignments
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_address(i_logical_address);
        end
        if (i_rst_n && o_result_valid) begin
            sb.check_result(t_xlat_beat'{o_physical_address, o_tlb_hit, o_page_fault,
                                         o_access_total, o_hit_total, o_fault_total});
        end
    end

    // watchdog on forward progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // one address beat; idle_pct is the chance of a gap cycle before it
    task automatic send_address(input logic [ADDR_W-1:0] addr, input int idle_pct);
        logic [PAGE_W-1:0] page;
        page = addr[ADDR_W-1:OFFSET_BITS];
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_logical_address <= addr;
        // busy is high in the update cycle after each accepted beat
        do @(posedge i_clk); while (busy);
        recent_pages = {recent_pages, page};
        if (recent_pages.size() > RECENT_DEPTH) begin
            void'(recent_pages.pop_front());
        end
        if (!page_seen[page]) begin
            page_seen[page] = 1'b1;
            known_pages = {known_pages, page};
            pages_touched++;
        end
    endtask

    // hold start low until every pending translation has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    // half the beats reuse a recent page (tlb hits), three in ten revisit an older
    // page (likely evicted, so a table read), the rest pick any page (may fault)
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [PAGE_W-1:0]      page;
        logic [OFFSET_BITS-1:0] offset;
        int                     r;
        r      = $urandom_range(99);
        offset = OFFSET_BITS'($urandom());
        if (r < 50 && recent_pages.size() > 0) begin
            page = recent_pages[$urandom_range(recent_pages.size() - 1)];
        end else if (r < 80 && known_pages.size() > 0) begin
            page = known_pages[$urandom_range(known_pages.size() - 1)];
        end else begin
            page = PAGE_W'($urandom_range(PAGE_COUNT - 1));
        end
        return {page, offset};
    endfunction

    initial begin
        logic [ADDR_W-1:0] directed_q[$];
        int                idle_pct[3];

        idle_pct          = '{34, 73, 0};
        i_rst_n           <= 1'b0;
        start             <= 1'b0;
        i_logical_address <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // page 0 first: an empty tlb must not hit on its invalid entries
        directed_q = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00};
        // sixteen new pages wrap the refill pointer and evict pages 0 and 255
        for (int p = 1; p <= 16; p++) begin
            directed_q = {directed_q, {p[7:0], 8'(p * 37)}};
        end
        // evicted pages come back through the table, page 15 still hits
        directed_q = {directed_q, 16'h0042, 16'hFFAA, 16'h0F0F, 16'h80A5, 16'h7F5A};
        foreach (directed_q[i]) begin
            send_address(directed_q[i], 0);
        end
        drain_results();

        // random phases: moderate gaps, heavy gaps, back to back
        for (int ph = 0; ph < 3; ph++) begin
            repeat (ITEMS_PER_PHASE) send_address(pick_address(), idle_pct[ph]);
            drain_results();
        end

        repeat (4 * RESULT_LATENCY) @(posedge i_clk);

        $display("run covered %0d translations: %0d tlb hits, %0d page faults",
                 sb.checked, sb.seen_hits, sb.seen_faults);
        $display("%0d distinct pages used", pages_touched);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d translations still pending",
                     sb.errors, sb.outstanding());
            $display("status: fail");
        end
        $finish;
    end

endmodule
